@@ rtl/rmsi_pkg.sv @@
// Shared constants and types for the running median sorted-insert block.
package rmsi_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W = 32;
    localparam int SUM_W = DATA_W + 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_W = 7;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic  shift_en;
        data_t sample;
        cnt_t  count;
    } ins_ctrl_t;

endpackage

@@ rtl/rmsi_cell.sv @@
// One storage cell of the sorted insertion chain.
module rmsi_cell (
    input  logic                clk,
    input  rmsi_pkg::ins_ctrl_t ctrl,
    input  rmsi_pkg::cnt_t      idx,
    input  rmsi_pkg::data_t     prev_val,
    input  logic                prev_lt,
    output rmsi_pkg::data_t     val,
    output logic                lt
);

    rmsi_pkg::data_t val_reg;
    rmsi_pkg::data_t val_next;

    // A cell holds a value below the sample only if it is occupied.
    assign lt = (idx < ctrl.count) && (val_reg < ctrl.sample);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.shift_en && !lt)
        begin
            if (prev_lt)
            begin
                val_next = ctrl.sample;
            end
            else
            begin
                val_next = prev_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

@@ rtl/rmsi_median.sv @@
// Selection of the two middle cells and their sum.
module rmsi_median (
    input  rmsi_pkg::data_t vals [rmsi_pkg::CAPACITY],
    input  rmsi_pkg::cnt_t  count,
    output rmsi_pkg::sum_t  median_sum
);

    rmsi_pkg::cnt_t  hi_idx;
    rmsi_pkg::cnt_t  lo_idx;
    rmsi_pkg::data_t hi_val;
    rmsi_pkg::data_t lo_val;

    assign hi_idx = count >> 1;
    assign lo_idx = (count - rmsi_pkg::cnt_t'(1)) >> 1;

    always_comb
    begin
        hi_val = '0;
        lo_val = '0;
        for (int i = 0; i < rmsi_pkg::CAPACITY; i++)
        begin
            if (hi_idx == rmsi_pkg::cnt_t'(i))
            begin
                hi_val = hi_val | vals[i];
            end
            if (lo_idx == rmsi_pkg::cnt_t'(i))
            begin
                lo_val = lo_val | vals[i];
            end
        end
    end

    always_comb
    begin
        if (count == '0)
        begin
            median_sum = '0;
        end
        else
        begin
            median_sum = rmsi_pkg::sum_t'(hi_val) + rmsi_pkg::sum_t'(lo_val);
        end
    end

endmodule

@@ rtl/running_median_sorted_insert_top.sv @@
// Top level of the running median block built on a sorted insertion chain.
// A word is inserted into the cell chain at acceptance; the middle-cell selection
// for it is registered in the calculation state once the output register is free.
// No new word is taken until that result is registered. Reset clears the
// count and the handshake state; cell contents are undefined until written.
module running_median_sorted_insert_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [31:0]           sample,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [32:0]           median_doubled,
    output logic [6:0]                   element_count,
    output logic                         refused_full
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_CALC = 1'b1;

    logic                state_reg;
    logic                state_next;
    rmsi_pkg::cnt_t      count_reg;
    rmsi_pkg::cnt_t      count_next;
    logic                refused_reg;
    logic                refused_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    rmsi_pkg::sum_t      median_reg;
    rmsi_pkg::sum_t      median_next;
    logic [rmsi_pkg::OUT_CNT_W-1:0] ecount_reg;
    logic [rmsi_pkg::OUT_CNT_W-1:0] ecount_next;
    logic                refused_out_reg;
    logic                refused_out_next;

    logic                accept;
    logic                full;
    logic                finish;
    rmsi_pkg::ins_ctrl_t ctrl;
    rmsi_pkg::data_t     vals [rmsi_pkg::CAPACITY];
    logic                lts [rmsi_pkg::CAPACITY];
    rmsi_pkg::sum_t      median_sum;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept = in_valid && in_ready;
    assign full = (count_reg == rmsi_pkg::cnt_t'(rmsi_pkg::CAPACITY));
    assign finish = (state_reg == ST_CALC) && (!out_valid_reg || out_ready);

    assign ctrl.shift_en = accept && !full;
    assign ctrl.sample = sample;
    assign ctrl.count = count_reg;

    genvar g;
    generate
        for (g = 0; g < rmsi_pkg::CAPACITY; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                rmsi_cell u_cell (
                    .clk      (clk),
                    .ctrl     (ctrl),
                    .idx      (rmsi_pkg::cnt_t'(g)),
                    .prev_val (sample),
                    .prev_lt  (1'b1),
                    .val      (vals[g]),
                    .lt       (lts[g])
                );
            end
            else
            begin : g_rest
                rmsi_cell u_cell (
                    .clk      (clk),
                    .ctrl     (ctrl),
                    .idx      (rmsi_pkg::cnt_t'(g)),
                    .prev_val (vals[g-1]),
                    .prev_lt  (lts[g-1]),
                    .val      (vals[g]),
                    .lt       (lts[g])
                );
            end
        end
    endgenerate

    rmsi_median u_median (
        .vals       (vals),
        .count      (count_reg),
        .median_sum (median_sum)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        refused_next = refused_reg;
        out_valid_next = out_valid_reg;
        median_next = median_reg;
        ecount_next = ecount_reg;
        refused_out_next = refused_out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    refused_next = full;
                    if (!full)
                    begin
                        count_next = count_reg + rmsi_pkg::cnt_t'(1);
                    end
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (finish)
                begin
                    median_next = median_sum;
                    ecount_next = rmsi_pkg::OUT_CNT_W'(count_reg);
                    refused_out_next = refused_reg;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            refused_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            refused_reg <= refused_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        median_reg <= median_next;
        ecount_reg <= ecount_next;
        refused_out_reg <= refused_out_next;
    end

    assign out_valid = out_valid_reg;
    assign median_doubled = median_reg;
    assign element_count = ecount_reg;
    assign refused_full = refused_out_reg;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Testbench for the running median block: a directed table, then random words, all checked.
module tb;

    localparam int RANDOM_WORDS = 750;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AFTER = 120;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        rmsi_pkg::sum_t median;
        logic [6:0]     count;
        logic           refused;
    } median_result_t;

    typedef struct {
        rmsi_pkg::data_t sample;
        bit              typed;
        longint          median;
        int              count;
        bit              refused;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    rmsi_pkg::data_t sample = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    rmsi_pkg::sum_t median_doubled;
    logic [6:0] element_count;
    logic refused_full;

    logic row_typed = 1'b0;
    median_result_t row_result = '0;

    rmsi_pkg::data_t sorted_store [rmsi_pkg::CAPACITY];
    int store_len = 0;
    median_result_t medians_pending [$];
    stim_row_t stim_rows [$];
    int mismatch_count = 0;
    int words_in = 0;
    int cycle_count = 0;
    int send_idle_pct = 22;
    int recv_idle_pct = 61;

    running_median_sorted_insert_top uut (.*);

    always #5 clk = ~clk;

    function automatic median_result_t insert_and_median(rmsi_pkg::data_t v);
        median_result_t r;
        int pos;
        r.refused = (store_len >= rmsi_pkg::CAPACITY);
        if (!r.refused)
        begin
            pos = 0;
            while (pos < store_len && sorted_store[pos] < v)
                pos++;
            for (int i = store_len; i > pos; i--)
                sorted_store[i] = sorted_store[i - 1];
            sorted_store[pos] = v;
            store_len++;
        end
        if (store_len == 0)
            r.median = '0;
        else if (store_len % 2 == 1)
            r.median = rmsi_pkg::sum_t'(sorted_store[store_len / 2])
                       + rmsi_pkg::sum_t'(sorted_store[store_len / 2]);
        else
            r.median = rmsi_pkg::sum_t'(sorted_store[store_len / 2])
                       + rmsi_pkg::sum_t'(sorted_store[store_len / 2 - 1]);
        r.count = 7'(store_len);
        return r;
    endfunction

    task automatic add_row(rmsi_pkg::data_t s, bit t, longint m, int c, bit r);
        stim_row_t row;
        row = '{s, t, m, c, r};
        stim_rows = {stim_rows, row};
    endtask

    task automatic note_mismatch(bit unexpected, median_result_t want, median_result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            if (unexpected)
                $display("unexpected word: median %0d count %0d refused %0b",
                         $signed(got.median), got.count, got.refused);
            else
                $display("mismatch: expected median %0d count %0d refused %0b, got %0d %0d %0b",
                         $signed(want.median), want.count, want.refused,
                         $signed(got.median), got.count, got.refused);
        end
    endtask

    task automatic send_word(rmsi_pkg::data_t v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= v;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    always @(posedge clk)
    begin : monitor
        median_result_t want;
        median_result_t got;
        if (in_valid && in_ready)
        begin
            want = insert_and_median(sample);
            if (row_typed)
                want = row_result;
            medians_pending = {medians_pending, want};
            words_in <= words_in + 1;
        end
        if (out_valid && out_ready)
        begin
            got = '{median_doubled, element_count, refused_full};
            if (medians_pending.size() == 0)
                note_mismatch(1'b1, '0, got);
            else
            begin
                want = medians_pending.pop_front();
                if (got !== want)
                    note_mismatch(1'b0, want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // The receiver holds off once for a long stretch so that the block backs up.
    initial
    begin : receiver
        bit held;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && words_in >= HOLD_AFTER)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial
    begin : stimulus
        rmsi_pkg::data_t v;
        rmsi_pkg::data_t last_v;
        int kind;
        add_row(32'h8000_0000, 1'b1, -64'sd4294967296, 1, 1'b0);
        add_row(32'h7FFF_FFFF, 1'b1, -64'sd1, 2, 1'b0);
        add_row(32'h0000_0000, 1'b1, 64'sd0, 3, 1'b0);
        add_row(32'h7FFF_FFFF, 1'b1, 64'sd2147483647, 4, 1'b0);
        add_row(32'h7FFF_FFFF, 1'b1, 64'sd4294967294, 5, 1'b0);
        add_row(32'h8000_0000, 1'b1, 64'sd2147483647, 6, 1'b0);
        add_row(32'h8000_0000, 1'b1, 64'sd0, 7, 1'b0);
        add_row(32'hFFFF_FFFF, 1'b1, -64'sd1, 8, 1'b0);
        add_row(32'h0000_0001, 1'b0, 0, 0, 1'b0);
        add_row(32'hFFFF_FFFF, 1'b0, 0, 0, 1'b0);
        add_row(32'h0000_0005, 1'b0, 0, 0, 1'b0);
        add_row(32'h0000_0005, 1'b0, 0, 0, 1'b0);
        add_row(32'h0000_0005, 1'b0, 0, 0, 1'b0);
        add_row(32'h5555_5555, 1'b0, 0, 0, 1'b0);
        add_row(32'hAAAA_AAAA, 1'b0, 0, 0, 1'b0);
        add_row(32'h7FFF_0000, 1'b0, 0, 0, 1'b0);
        add_row(32'h0000_FFFF, 1'b0, 0, 0, 1'b0);
        add_row(32'h0000_0064, 1'b0, 0, 0, 1'b0);
        add_row(32'hFFFF_FF9C, 1'b0, 0, 0, 1'b0);
        add_row(32'h4000_0000, 1'b0, 0, 0, 1'b0);
        add_row(32'hC000_0000, 1'b0, 0, 0, 1'b0);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            row_typed <= stim_rows[i].typed;
            row_result <= '{rmsi_pkg::sum_t'(stim_rows[i].median), 7'(stim_rows[i].count),
                            stim_rows[i].refused};
            send_word(stim_rows[i].sample);
        end

        row_typed <= 1'b0;
        last_v = '0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS / 3)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 22;
            end
            if (n == 2 * RANDOM_WORDS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: v = rmsi_pkg::data_t'($urandom);
                4, 5:       v = rmsi_pkg::data_t'($urandom_range(0, 64)) - 32;
                6:
                begin
                    case ($urandom_range(0, 3))
                        0: v = 32'h8000_0000;
                        1: v = 32'h7FFF_FFFF;
                        2: v = 32'hFFFF_FFFF;
                        default: v = '0;
                    endcase
                end
                7, 8:       v = last_v + rmsi_pkg::data_t'($urandom_range(0, 2)) - 1;
                default:    v = last_v;
            endcase
            last_v = v;
            send_word(v);
        end
        in_valid <= 1'b0;

        while (medians_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ running_median_sorted_insert_top.f @@
rtl/rmsi_pkg.sv
rtl/rmsi_cell.sv
rtl/rmsi_median.sv
rtl/running_median_sorted_insert_top.sv
test/tb.sv
